// ----- rtl/rgbled_pkg.sv -----
`default_nettype none
package rgbled_pkg;

  // columns per row, one pixel lane each
  localparam int LANES = 8;
  localparam int NIB_W = 4;
  localparam int PIX_W = 3 * NIB_W;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_FRAME  = 2'd1,
    OP_TICK   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_PIX1,
    ST_BYTE_OUT,
    ST_ROW_RD,
    ST_ROW_OUT
  } st_t;

  typedef struct packed {
    logic capture;
    logic byte_wr;
    logic pix_wr1;
    logic frame_end;
    logic tick;
    logic row_rd;
    logic row_inc;
    logic load_byte_out;
    logic load_row_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic group_full;
    logic row_last;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/rgbled_ctrl.sv -----
`default_nettype none
module rgbled_ctrl
  import rgbled_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  stat_t      status,
  output cmd_t       cmd
);

  st_t  state;
  st_t  state_next;
  logic accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_BYTE: state_next = ST_BYTE;
            OP_TICK: state_next = ST_ROW_RD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_BYTE:     state_next = status.group_full ? ST_PIX1 : ST_BYTE_OUT;
      ST_PIX1:     state_next = ST_BYTE_OUT;
      ST_BYTE_OUT: if (status.out_free) state_next = ST_IDLE;
      ST_ROW_RD:   state_next = ST_ROW_OUT;
      ST_ROW_OUT: begin
        if (status.out_free) state_next = status.row_last ? ST_IDLE : ST_ROW_RD;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.capture   = in_valid && (operation == OP_BYTE);
        cmd.frame_end = in_valid && (operation == OP_FRAME);
        cmd.tick      = in_valid && (operation == OP_TICK);
      end
      ST_BYTE:     cmd.byte_wr = 1'b1;
      ST_PIX1:     cmd.pix_wr1 = 1'b1;
      ST_BYTE_OUT: cmd.load_byte_out = status.out_free;
      ST_ROW_RD:   cmd.row_rd = 1'b1;
      ST_ROW_OUT: begin
        cmd.load_row_out = status.out_free;
        cmd.row_inc      = status.out_free && !status.row_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_byte_out || cmd.load_row_out) |-> status.out_free)
    else $error("result loaded over a pending beat");

  a_tick_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_TICK) |=> state == ST_ROW_RD)
    else $error("refresh tick did not start a row read");

  a_pix_after_byte: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PIX1) |-> ($past(state) == ST_BYTE && $past(status.group_full)))
    else $error("second pixel write without a full group");

endmodule
`default_nettype wire

// ----- rtl/rgbled_dpath.sv -----
`default_nettype none
module rgbled_dpath
  import rgbled_pkg::*;
#(
  parameter int PIXEL_COUNT = 64,
  parameter int ROW_COUNT   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] spi_byte,
  input  cmd_t       cmd,
  output stat_t      status,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pass_byte,
  output logic [7:0] row_select,
  output logic [7:0] red_bits,
  output logic [7:0] green_bits,
  output logic [7:0] blue_bits,
  output logic       last
);

  localparam int LINE_LEN = (PIXEL_COUNT * 3) / 2;
  localparam int PP_W     = $clog2(PIXEL_COUNT);
  localparam int FC_W     = $clog2(PIXEL_COUNT + 1);
  localparam int DP_W     = $clog2(LINE_LEN);
  localparam int HW_W     = $clog2(LINE_LEN + 1);
  localparam int MROWS    = (PIXEL_COUNT + LANES - 1) / LANES;
  localparam int MDEPTH   = 2 * MROWS;
  localparam int MA_W     = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int RC_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CMP_W    = ((RC_W + 3 > FC_W) ? RC_W + 3 : FC_W) + 1;

  // receive state
  logic [7:0]      byte_q;
  logic [7:0]      b0;
  logic [7:0]      b1;
  logic [1:0]      bp;
  logic [DP_W-1:0] dp;
  logic [DP_W-1:0] dp_nxt;
  logic [HW_W-1:0] hw;
  logic [PP_W-1:0] pp;
  logic [PP_W-1:0] pp1;
  logic [PP_W:0]   pp_sum;
  logic            disp;
  logic [FC_W-1:0] fill [2];
  logic [NIB_W-1:0] pwm;
  logic [RC_W-1:0] row;

  // delay line
  logic [7:0] dl_mem [LINE_LEN];
  logic [7:0] pass_q;
  logic       pass_ok;

  // pixel lanes
  logic [PIX_W-1:0] lane_mem [LANES][MDEPTH];
  logic [PIX_W-1:0] rd_q [LANES];
  logic             wr_en;
  logic [PP_W-1:0]  wr_idx;
  logic [PP_W-1:0]  wr_row;
  logic [2:0]       wr_lane;
  logic [MA_W-1:0]  wr_addr;
  logic [PIX_W-1:0] wr_data;
  logic             rd_en;
  logic [MA_W-1:0]  rd_addr;

  logic [7:0] sel_row;
  logic [7:0] red_c;
  logic [7:0] grn_c;
  logic [7:0] blu_c;
  logic [CMP_W-1:0] pix;

  assign dp_nxt = (dp == DP_W'(LINE_LEN - 1)) ? '0 : dp + 1'b1;
  assign pp1    = (pp == PP_W'(PIXEL_COUNT - 1)) ? '0 : pp + 1'b1;
  assign pp_sum = {1'b0, pp} + (PP_W + 1)'(2);

  // first pixel goes with the third byte, second one in the cycle after
  assign wr_en   = (cmd.byte_wr && (bp == 2'd2)) || cmd.pix_wr1;
  assign wr_idx  = cmd.pix_wr1 ? pp1 : pp;
  assign wr_row  = wr_idx >> 3;
  assign wr_lane = 3'(wr_idx);
  assign wr_addr = (disp ? MA_W'(0) : MA_W'(MROWS)) + MA_W'(wr_row);
  assign wr_data = cmd.pix_wr1 ? {b1[3:0], byte_q}
                               : {b0, b1[7:4]};

  assign rd_en   = cmd.row_rd && (CMP_W'(row) < CMP_W'(MROWS));
  assign rd_addr = (disp ? MA_W'(MROWS) : MA_W'(0)) + MA_W'(row);

  always_ff @(posedge clk) begin
    if (cmd.capture) byte_q <= spi_byte;
    if (cmd.byte_wr && bp == 2'd0) b0 <= byte_q;
    if (cmd.byte_wr && bp == 2'd1) b1 <= byte_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp      <= '0;
      dp      <= '0;
      hw      <= '0;
      pp      <= '0;
      disp    <= 1'b0;
      fill[0] <= '0;
      fill[1] <= '0;
      pwm     <= '0;
      row     <= '0;
    end else begin
      if (cmd.frame_end) begin
        disp <= ~disp;
        pp   <= '0;
        dp   <= '0;
        bp   <= '0;
      end
      if (cmd.byte_wr) begin
        dp <= dp_nxt;
        bp <= (bp == 2'd2) ? 2'd0 : bp + 2'd1;
        if (HW_W'(dp) + 1'b1 > hw) hw <= HW_W'(dp) + 1'b1;
      end
      if (wr_en && (FC_W'(wr_idx) + 1'b1 > fill[~disp])) begin
        fill[~disp] <= FC_W'(wr_idx) + 1'b1;
      end
      if (cmd.pix_wr1) begin
        pp <= (pp_sum >= (PP_W + 1)'(PIXEL_COUNT)) ? '0 : pp_sum[PP_W-1:0];
      end
      if (cmd.tick) begin
        pwm <= pwm + 1'b1;
        row <= '0;
      end else if (cmd.row_inc) begin
        row <= row + 1'b1;
      end
    end
  end

  // delay line: write the new byte, read the slot after it
  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      dl_mem[dp] <= byte_q;
      pass_q     <= dl_mem[dp_nxt];
      pass_ok    <= HW_W'(dp_nxt) < hw;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (wr_en && wr_lane == 3'(l)) lane_mem[l][wr_addr] <= wr_data;
      if (rd_en) rd_q[l] <= lane_mem[l][rd_addr];
    end
  end

  always_comb begin
    red_c = '0;
    grn_c = '0;
    blu_c = '0;
    pix   = '0;
    for (int c = 0; c < LANES; c++) begin
      pix = (CMP_W'(row) << 3) | CMP_W'(c);
      if (pix < CMP_W'(fill[disp])) begin
        red_c[c] = rd_q[c][3*NIB_W-1:2*NIB_W] > pwm;
        grn_c[c] = rd_q[c][2*NIB_W-1:NIB_W] > pwm;
        blu_c[c] = rd_q[c][NIB_W-1:0] > pwm;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      sel_row[k] = (32'(row) == k);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte_out) begin
      pass_byte  <= pass_ok ? pass_q : 8'd0;
      row_select <= '0;
      red_bits   <= '0;
      green_bits <= '0;
      blue_bits  <= '0;
      last       <= 1'b1;
    end else if (cmd.load_row_out) begin
      pass_byte  <= '0;
      row_select <= sel_row;
      red_bits   <= red_c;
      green_bits <= grn_c;
      blue_bits  <= blu_c;
      last       <= status.row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_byte_out || cmd.load_row_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free   = !out_valid || !out_stall;
  assign status.group_full = (bp == 2'd2);
  assign status.row_last   = (row == RC_W'(ROW_COUNT - 1));

  a_pp_range: assert property (@(posedge clk) disable iff (rst)
    (PP_W + 1)'(pp) < (PP_W + 1)'(PIXEL_COUNT))
    else $error("pixel pointer out of range");

  a_hw_range: assert property (@(posedge clk) disable iff (rst)
    (HW_W + 1)'(hw) <= (HW_W + 1)'(LINE_LEN))
    else $error("delay line fill mark beyond its length");

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(row_select))
    else $error("row select not one-hot");

endmodule
`default_nettype wire

// ----- rtl/rgb_led_matrix_pwm_controller_core.sv -----
`default_nettype none
// serial byte: the sequencer steps through a byte write and then a result load, with
//   a second pixel write between them on every third byte, which writes its two
//   pixels one after the other; input is taken again only once it is back in idle
// frame end and unused code: handled in idle, no result; refresh tick: for each of
//   the ROW_COUNT rows, one row read of all eight pixel lanes then one result beat
// a stalled result holds the sequencer in its result load state
// rst is synchronous: clears pointers, bank select, pwm phase and fill marks; memories are
//   not swept, fill marks make never-written entries read as zero
module rgb_led_matrix_pwm_controller_core
  import rgbled_pkg::*;
#(
  parameter int PIXEL_COUNT = 64,
  parameter int ROW_COUNT   = 8
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] spi_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pass_byte,
  output logic [7:0] row_select,
  output logic [7:0] red_bits,
  output logic [7:0] green_bits,
  output logic [7:0] blue_bits,
  output logic       last
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t status;

  // sequencer: one item at a time, stalls input while a byte or tick is in work
  rgbled_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: delay line, two pixel banks as eight column lanes, pwm compare,
  // result register
  rgbled_dpath #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .ROW_COUNT   (ROW_COUNT)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .spi_byte   (spi_byte),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pass_byte  (pass_byte),
    .row_select (row_select),
    .red_bits   (red_bits),
    .green_bits (green_bits),
    .blue_bits  (blue_bits),
    .last       (last)
  );

endmodule
`default_nettype wire

// ----- tb/sv/led_matrix_check_pkg.sv -----
package led_matrix_check_pkg;
  import rgbled_pkg::*;

  localparam int PIXELS   = 64;
  localparam int ROWS     = 8;
  localparam int LINE_LEN = (PIXELS * 3) / 2;

  typedef struct packed {
    logic [7:0] pass_byte;
    logic [7:0] row_select;
    logic [7:0] red_bits;
    logic [7:0] green_bits;
    logic [7:0] blue_bits;
    logic       last;
  } row_beat_t;

  class matrix_scoreboard;
    // own copy of the block state
    logic [PIX_W-1:0] pix_mem [2*PIXELS];
    logic [7:0]       dly_line [LINE_LEN];
    bit               disp_bank;
    int unsigned      pix_ptr;
    int unsigned      grp_pos;
    int unsigned      dly_ptr;
    logic [NIB_W-1:0] pwm;

    row_beat_t   beats_due[$];
    int unsigned errors;
    int unsigned n_byte, n_frame, n_tick, n_ignored, n_beats;

    function new();
      foreach (pix_mem[i]) pix_mem[i] = '0;
      foreach (dly_line[i]) dly_line[i] = '0;
      disp_bank = 1'b0;
      pix_ptr   = 0;
      grp_pos   = 0;
      dly_ptr   = 0;
      pwm       = '0;
      errors    = 0;
      n_byte    = 0;
      n_frame   = 0;
      n_tick    = 0;
      n_ignored = 0;
      n_beats   = 0;
    endfunction

    // writes go to the bank not on display
    function void put_pixel(int unsigned idx, logic [3:0] r, logic [3:0] g, logic [3:0] b);
      int unsigned bank;
      bank = disp_bank ? 0 : 1;
      pix_mem[bank * PIXELS + (idx % PIXELS)] = {r, g, b};
    endfunction

    function void note_item(op_t op, logic [7:0] b);
      row_beat_t   beat;
      logic [7:0]  b0, b1;
      logic [PIX_W-1:0] v;
      int unsigned base, pix;
      case (op)
        OP_BYTE: begin
          n_byte++;
          dly_line[dly_ptr] = b;
          if (grp_pos == 2) begin
            b0 = dly_line[(dly_ptr + LINE_LEN - 2) % LINE_LEN];
            b1 = dly_line[(dly_ptr + LINE_LEN - 1) % LINE_LEN];
            put_pixel(pix_ptr, b0[7:4], b0[3:0], b1[7:4]);
            put_pixel(pix_ptr + 1, b1[3:0], b[7:4], b[3:0]);
            pix_ptr += 2;
            if (pix_ptr >= PIXELS) pix_ptr = 0;
          end
          dly_ptr = (dly_ptr + 1) % LINE_LEN;
          grp_pos = (grp_pos >= 2) ? 0 : grp_pos + 1;
          beat = '0;
          beat.pass_byte = dly_line[dly_ptr];
          beat.last = 1'b1;
          beats_due.push_back(beat);
        end
        OP_FRAME: begin
          n_frame++;
          disp_bank = ~disp_bank;
          pix_ptr = 0;
          dly_ptr = 0;
          grp_pos = 0;
        end
        OP_TICK: begin
          n_tick++;
          base = disp_bank ? PIXELS : 0;
          pwm = pwm + 1'b1;
          for (int row = 0; row < ROWS; row++) begin
            beat = '0;
            for (int col = 0; col < LANES; col++) begin
              pix = row * LANES + col;
              if (pix < PIXELS) begin
                v = pix_mem[base + pix];
                if (pwm < v[11:8]) beat.red_bits[col] = 1'b1;
                if (pwm < v[7:4]) beat.green_bits[col] = 1'b1;
                if (pwm < v[3:0]) beat.blue_bits[col] = 1'b1;
              end
            end
            beat.row_select = (row < 8) ? 8'(1 << row) : 8'h00;
            beat.last = (row == ROWS - 1);
            beats_due.push_back(beat);
          end
        end
        default: n_ignored++;
      endcase
    endfunction

    function int unsigned field_diff(string field, logic [7:0] want, logic [7:0] seen,
                                     time stamp);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", stamp, field, want, seen);
        return 1;
      end
      return 0;
    endfunction

    function void check_beat(row_beat_t got, time stamp);
      row_beat_t want;
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual 0x%012h", stamp, got);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      n_beats++;
      errors += field_diff("pass_byte", want.pass_byte, got.pass_byte, stamp);
      errors += field_diff("row_select", want.row_select, got.row_select, stamp);
      errors += field_diff("red_bits", want.red_bits, got.red_bits, stamp);
      errors += field_diff("green_bits", want.green_bits, got.green_bits, stamp);
      errors += field_diff("blue_bits", want.blue_bits, got.blue_bits, stamp);
      errors += field_diff("last", {7'b0, want.last}, {7'b0, got.last}, stamp);
    endfunction

    function int unsigned pending();
      return beats_due.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/rgb_led_matrix_pwm_controller_core_tb.sv -----
module rgb_led_matrix_pwm_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbled_pkg::*;
  import led_matrix_check_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 8;
  // longest correct quiet spell is a refresh read plus a full receiver stall, well under this
  localparam int QUIET_LIMIT  = 500;
  // room for a refresh tick's row reads and beats, plus stalls on its beats
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 130;
  localparam int MAX_GAP      = 6;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] operation;
  logic [7:0] spi_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] pass_byte;
  logic [7:0] row_select;
  logic [7:0] red_bits;
  logic [7:0] green_bits;
  logic [7:0] blue_bits;
  logic       last;

  // when set, neither side inserts gaps or stalls
  bit          calm;
  int unsigned quiet_cycles;
  int unsigned random_sent;

  matrix_scoreboard sb;

  rgb_led_matrix_pwm_controller_core #(
    .PIXEL_COUNT(PIXELS),
    .ROW_COUNT  (ROWS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .spi_byte  (spi_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pass_byte (pass_byte),
    .row_select(row_select),
    .red_bits  (red_bits),
    .green_bits(green_bits),
    .blue_bits (blue_bits),
    .last      (last)
  );

  always #CLK_HALF clk = ~clk;

  // one input beat: optional idle gap, then hold the payload until it is taken.
  // called and left at a falling edge, so inputs only move there
  task automatic send_item(op_t op, logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = op;
    spi_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, b);
    @(negedge clk);
  endtask

  // well-formed frame: frame end, a run of bytes, frame end to show it, then refresh ticks
  task automatic send_frame(int unsigned n_bytes, int unsigned n_ticks);
    send_item(OP_FRAME, 8'($urandom));
    repeat (n_bytes) send_item(OP_BYTE, 8'($urandom));
    send_item(OP_FRAME, 8'($urandom));
    repeat (n_ticks) send_item(OP_TICK, 8'($urandom));
    random_sent += n_bytes + n_ticks + 2;
  endtask

  // result side: draw a stall length per beat, then wait for the beat with stall low
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // every accepted result beat goes against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_beat('{pass_byte, row_select, red_bits, green_bits, blue_bits, last}, $time);
    end
  end

  // watchdog on cycles where neither channel moves a beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    in_valid    = 1'b0;
    operation   = OP_BYTE;
    spi_byte    = 8'h00;
    rst         = 1'b1;
    calm        = 1'b0;
    random_sent = 0;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: unused code ignored, refresh of an all-dark bank
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_TICK, 8'h00);
    // first group: full white pixel then a blue one, extremes of each nibble
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hF0);
    send_item(OP_BYTE, 8'h0F);
    // second group with alternating bit patterns
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hA5);
    send_item(OP_BYTE, 8'h5A);
    // swap banks so the written pixels go on display, then sweep a few pwm phases
    send_item(OP_FRAME, 8'hFF);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h81);
    send_item(OP_UNUSED, 8'h00);
    // frame end in the middle of a group, then show the other bank
    send_item(OP_BYTE, 8'h12);
    send_item(OP_FRAME, 8'h00);
    send_item(OP_TICK, 8'h7E);
    send_item(OP_TICK, 8'hC3);

    // one overlong frame so both the delay line and the pixel pointer wrap
    send_frame(LINE_LEN + 2, 4);

    while (random_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        // noise: any code, any byte, any order
        repeat ($urandom_range(1, 4)) begin
          send_item(op_t'($urandom_range(0, 3)), 8'($urandom));
          random_sent++;
        end
      end else if (pick == 1) begin
        send_frame($urandom_range(3, 12) * 3, $urandom_range(2, 5));
      end else begin
        send_frame($urandom_range(1, 24), $urandom_range(1, 4));
      end
    end
    calm = 1'b0;
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // extra cycles so a stray beat after the last one is still caught
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("covered %0d serial bytes, %0d frame ends, %0d refresh ticks, %0d ignored codes",
             sb.n_byte, sb.n_frame, sb.n_tick, sb.n_ignored);
    $display("%0d result beats compared, %0d mismatches", sb.n_beats, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rgbled_pkg.sv
rtl/rgbled_ctrl.sv
rtl/rgbled_dpath.sv
rtl/rgb_led_matrix_pwm_controller_core.sv
tb/sv/led_matrix_check_pkg.sv
tb/sv/rgb_led_matrix_pwm_controller_core_tb.sv
